// ----- hdl/dsat_pkg.sv -----
`timescale 1ns / 1ps

package dsat_pkg;

  // Width of logical sector arithmetic; results wrap modulo 2^LOGICAL_BITS
  localparam int LOGICAL_BITS = 24;
  // Width of the logical fields on the ports
  localparam int LOGICAL_PORT_BITS = 24;
  // Geometry values are bytes; one multiply pass takes one step per bit
  localparam int GEOM_BITS = 8;
  // Step counter covers the longest pass (one divide step per logical bit)
  localparam int CNT_W = $clog2(LOGICAL_BITS + 1);
  // Shared adder carries one extra bit for the borrow of a trial subtract
  localparam int ADD_W = LOGICAL_BITS + 1;

  localparam logic [7:0]  JMP_NEAR      = 8'hE9;
  localparam logic [7:0]  JMP_SHORT     = 8'hEB;
  localparam logic [7:0]  MEDIA_MIN     = 8'hF8;
  localparam logic [23:0] SS_360K_TOTAL = 24'd720;
  localparam logic [15:0] GEOM_MAX      = 16'd255;
  localparam logic [7:0]  DEFAULT_SPT   = 8'd9;
  localparam logic [7:0]  SPT_MEDIA_DS  = 8'd8;

  typedef enum logic [1:0] {
    ACT_DETECT = 2'd0,
    ACT_P2L    = 2'd1,
    ACT_L2P    = 2'd2
  } action_t;

endpackage

// ----- hdl/dsat_if.sv -----
`timescale 1ns / 1ps

// Request channel: one translate or detect item
interface dsat_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  track_in;
  logic [7:0]  side_in;
  logic [7:0]  sector_in;
  logic [23:0] logical_in;
  logic [7:0]  boot_first_byte;
  logic [15:0] boot_sectors_field;
  logic [15:0] boot_heads_field;
  logic [7:0]  fat_media_byte;
  logic        read_failed;
  logic [23:0] total_sectors;

  modport source (
    output valid, action, track_in, side_in, sector_in, logical_in, boot_first_byte,
           boot_sectors_field, boot_heads_field, fat_media_byte, read_failed,
           total_sectors,
    input  ready
  );
  modport sink (
    input  valid, action, track_in, side_in, sector_in, logical_in, boot_first_byte,
           boot_sectors_field, boot_heads_field, fat_media_byte, read_failed,
           total_sectors,
    output ready
  );
endinterface

// Response channel: one result item per request item
interface dsat_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] logical_out;
  logic [7:0]  track_out;
  logic [7:0]  side_out;
  logic [7:0]  sector_out;
  logic [7:0]  geometry_sectors;
  logic [7:0]  geometry_sides;
  logic        not_ready;
  logic        out_of_range;

  modport source (
    output valid, logical_out, track_out, side_out, sector_out, geometry_sectors,
           geometry_sides, not_ready, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, logical_out, track_out, side_out, sector_out, geometry_sectors,
           geometry_sides, not_ready, out_of_range,
    output ready
  );
endinterface

// ----- hdl/disk_sector_address_translator_top.sv -----
`timescale 1ns / 1ps
// Floppy sector address translator.
// cmd carries one item: detect geometry, physical to logical, or logical to
// physical. rsp returns exactly one result item per command, in order, with
// the geometry in force after that command.
// cmd.ready is high only while the sequencer is idle; one item is worked at
// a time by a single shared adder under a small step counter.
// Work per item, from acceptance to the result register:
//   detect, logical 0 or 1, or not-ready translations: no arithmetic pass
//   physical to logical: 2 shift-add multiplies of 8 steps
//   logical to physical: 2 restoring divides of LOGICAL_BITS steps
// The next item is accepted in the cycle after a result is loaded, so the
// divide passes make logical to physical the slowest item.
// A finished result sits in the output register until rsp.ready; the
// sequencer accepts the next command meanwhile and waits at its end only if
// the register is still full.
// Reset clears the geometry to not detected (0 sectors, 0 sides) and empties
// the output register.
module disk_sector_address_translator_top (
  input  logic            clk,
  input  logic            rst,
  dsat_cmd_if.sink        cmd,
  dsat_rsp_if.source      rsp
);

  localparam int LB = dsat_pkg::LOGICAL_BITS;
  localparam int AW = dsat_pkg::ADD_W;
  localparam int CW = dsat_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  // Geometry
  logic [7:0] spt_q;
  logic [7:0] sc_q;

  // Item context
  dsat_pkg::action_t act_r;
  logic              nr_r;
  logic              long_r;
  logic [7:0]        sector_r;
  logic              phase;
  logic [CW-1:0]     cnt;

  // Shared datapath registers
  logic [LB-1:0] acc;
  logic [LB-1:0] mcand;
  logic [7:0]    mplier;
  logic [LB-1:0] quo;
  logic [7:0]    rem;

  // Output register
  logic        out_valid;
  logic [23:0] out_logical;
  logic [7:0]  out_track;
  logic [7:0]  out_side;
  logic [7:0]  out_sector;
  logic [7:0]  out_geo_spt;
  logic [7:0]  out_geo_sides;
  logic        out_nr;
  logic        out_oor;

  // Detection
  logic [7:0] det_spt;
  logic [7:0] det_sc;
  logic [7:0] fb_sc;
  logic       boot_ok;

  always_comb begin
    fb_sc   = (cmd.total_sectors == dsat_pkg::SS_360K_TOTAL) ? 8'd1 : 8'd2;
    boot_ok = (cmd.boot_sectors_field != 16'd0) &&
              (cmd.boot_sectors_field <= dsat_pkg::GEOM_MAX) &&
              (cmd.boot_heads_field != 16'd0) &&
              (cmd.boot_heads_field <= dsat_pkg::GEOM_MAX);
    det_spt = dsat_pkg::DEFAULT_SPT;
    det_sc  = fb_sc;
    if (cmd.read_failed) begin
      det_spt = dsat_pkg::DEFAULT_SPT;
      det_sc  = fb_sc;
    end else if (cmd.boot_first_byte == dsat_pkg::JMP_NEAR ||
                 cmd.boot_first_byte == dsat_pkg::JMP_SHORT) begin
      if (boot_ok) begin
        det_spt = cmd.boot_sectors_field[7:0];
        det_sc  = cmd.boot_heads_field[7:0];
      end
    end else if (cmd.fat_media_byte >= dsat_pkg::MEDIA_MIN) begin
      det_spt = cmd.fat_media_byte[1] ? dsat_pkg::SPT_MEDIA_DS : dsat_pkg::DEFAULT_SPT;
      det_sc  = cmd.fat_media_byte[0] ? 8'd2 : 8'd1;
    end
  end

  // Request decode
  logic [LB-1:0] lg_in;
  logic          trivial_p;

  assign lg_in     = LB'(cmd.logical_in);
  assign trivial_p = (cmd.track_in == 8'd0) && (cmd.side_in == 8'd0);

  // Shared adder: accumulate for multiply, trial subtract for divide
  logic [8:0]    div_sh;
  logic [7:0]    div_d;
  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic          add_cin;
  logic [AW-1:0] add_sum;

  assign div_sh = {rem, quo[LB-1]};
  assign div_d  = phase ? sc_q : spt_q;

  always_comb begin
    if (state == S_DIV) begin
      add_a   = AW'(div_sh);
      add_b   = ~AW'(div_d);
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, acc};
      add_b   = {1'b0, mcand};
      add_cin = 1'b0;
    end
    add_sum = add_a + add_b + AW'(add_cin);
  end

  logic out_free;
  assign out_free = !out_valid || rsp.ready;

  assign cmd.ready = (state == S_IDLE) && !rst;

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      spt_q     <= 8'd0;
      sc_q      <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      // drain the output register unless a new result loads it this cycle
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act_r  <= dsat_pkg::action_t'(cmd.action);
            nr_r   <= 1'b0;
            long_r <= 1'b0;
            phase  <= 1'b0;
            state  <= S_DONE;
            case (cmd.action)
              dsat_pkg::ACT_DETECT: begin
                spt_q <= det_spt;
                sc_q  <= det_sc;
              end
              dsat_pkg::ACT_P2L: begin
                sector_r <= cmd.sector_in;
                if (!trivial_p && sc_q == 8'd0) begin
                  nr_r <= 1'b1;
                end else begin
                  // first pass: side + sides * track
                  acc    <= LB'(cmd.side_in);
                  mcand  <= LB'(cmd.track_in);
                  mplier <= sc_q;
                  cnt    <= CW'(dsat_pkg::GEOM_BITS);
                  state  <= S_MUL;
                end
              end
              dsat_pkg::ACT_L2P: begin
                if (lg_in <= LB'(1)) begin
                  sector_r <= {7'd0, lg_in[0]} + 8'd1;
                end else if (sc_q == 8'd0 || spt_q == 8'd0) begin
                  nr_r     <= 1'b1;
                  sector_r <= 8'd0;
                end else begin
                  quo    <= lg_in;
                  rem    <= 8'd0;
                  cnt    <= CW'(LB);
                  long_r <= 1'b1;
                  state  <= S_DIV;
                end
              end
              default: begin
                sector_r <= 8'd0;
              end
            endcase
          end
        end

        S_MUL: begin
          if (cnt != '0) begin
            if (mplier[0]) begin
              acc <= add_sum[LB-1:0];
            end
            mcand  <= {mcand[LB-2:0], 1'b0};
            mplier <= {1'b0, mplier[7:1]};
            cnt    <= cnt - CW'(1);
          end else if (!phase) begin
            // second pass: sectors * (first pass) + sector - 1
            mcand  <= acc;
            acc    <= LB'(sector_r) - LB'(1);
            mplier <= spt_q;
            cnt    <= CW'(dsat_pkg::GEOM_BITS);
            phase  <= 1'b1;
          end else begin
            state <= S_DONE;
          end
        end

        S_DIV: begin
          if (cnt != '0) begin
            if (!add_sum[AW-1]) begin
              rem <= add_sum[7:0];
              quo <= {quo[LB-2:0], 1'b1};
            end else begin
              rem <= div_sh[7:0];
              quo <= {quo[LB-2:0], 1'b0};
            end
            cnt <= cnt - CW'(1);
          end else if (!phase) begin
            // remainder by sectors gives the sector; quotient goes on to sides
            sector_r <= rem + 8'd1;
            rem      <= 8'd0;
            cnt      <= CW'(LB);
            phase    <= 1'b1;
          end else begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_logical   <= (act_r == dsat_pkg::ACT_P2L && !nr_r) ? 24'(acc) : 24'd0;
            out_track     <= long_r ? quo[7:0] : 8'd0;
            out_side      <= long_r ? rem : 8'd0;
            out_sector    <= (act_r == dsat_pkg::ACT_L2P) ? sector_r : 8'd0;
            out_geo_spt   <= spt_q;
            out_geo_sides <= sc_q;
            out_nr        <= nr_r;
            out_oor       <= (act_r == dsat_pkg::ACT_P2L && !nr_r && sector_r == 8'd0) ||
                             (long_r && (|quo[LB-1:8]));
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.logical_out      = out_logical;
  assign rsp.track_out        = out_track;
  assign rsp.side_out         = out_side;
  assign rsp.sector_out       = out_sector;
  assign rsp.geometry_sectors = out_geo_spt;
  assign rsp.geometry_sides   = out_geo_sides;
  assign rsp.not_ready        = out_nr;
  assign rsp.out_of_range     = out_oor;

endmodule

// ----- bench/tb_disk_sector_address_translator_top.sv -----
`timescale 1ns / 1ps

module tb_disk_sector_address_translator_top;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 317;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 80;

  // One command item, fields in port order
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  track;
    logic [7:0]  side;
    logic [7:0]  sector;
    logic [23:0] logical;
    logic [7:0]  boot_first;
    logic [15:0] boot_spt;
    logic [15:0] boot_heads;
    logic [7:0]  media;
    logic        read_failed;
    logic [23:0] total;
  } xlat_req_t;

  // One result item, fields in port order
  typedef struct packed {
    logic [23:0] logical;
    logic [7:0]  track;
    logic [7:0]  side;
    logic [7:0]  sector;
    logic [7:0]  geo_spt;
    logic [7:0]  geo_sides;
    logic        not_ready;
    logic        out_of_range;
  } xlat_res_t;

  typedef struct {
    xlat_req_t req;
    bit        typed;
    xlat_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dsat_cmd_if cmd ();
  dsat_rsp_if rsp ();

  disk_sector_address_translator_top DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // Geometry as the predictor tracks it (0/0 = not detected)
  logic [7:0] geo_spt_q   = 8'd0;
  logic [7:0] geo_sides_q = 8'd0;

  xlat_res_t pending_xlat[$];
  stim_row_t stim_tab[$];
  int errors        = 0;
  int cycle_cnt     = 0;
  int send_idle_pct = 36;
  int rcv_idle_pct  = 72;
  bit press_phase   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Expected result of one item; updates the tracked geometry on detect
  function automatic xlat_res_t translate_addr(input xlat_req_t r);
    xlat_res_t   res;
    logic [63:0] lmask, base, lg, cyl, trk;
    bit          fb, trivial;
    res = '0;
    lmask = (64'd1 << dsat_pkg::LOGICAL_BITS) - 64'd1;
    fb = 1'b0;
    trivial = (r.track == 8'd0 && r.side == 8'd0);
    case (r.action)
      dsat_pkg::ACT_DETECT: begin
        // read error beats everything, then boot jump, then media byte
        if (r.read_failed) begin
          fb = 1'b1;
        end else if (r.boot_first == dsat_pkg::JMP_NEAR ||
                     r.boot_first == dsat_pkg::JMP_SHORT) begin
          if (r.boot_spt == 16'd0 || r.boot_spt > dsat_pkg::GEOM_MAX ||
              r.boot_heads == 16'd0 || r.boot_heads > dsat_pkg::GEOM_MAX) begin
            fb = 1'b1;
          end else begin
            geo_spt_q   = r.boot_spt[7:0];
            geo_sides_q = r.boot_heads[7:0];
          end
        end else if (r.media >= dsat_pkg::MEDIA_MIN) begin
          geo_spt_q   = r.media[1] ? dsat_pkg::SPT_MEDIA_DS : dsat_pkg::DEFAULT_SPT;
          geo_sides_q = r.media[0] ? 8'd2 : 8'd1;
        end else begin
          fb = 1'b1;
        end
        if (fb) begin
          geo_spt_q   = dsat_pkg::DEFAULT_SPT;
          geo_sides_q = (r.total == dsat_pkg::SS_360K_TOTAL) ? 8'd1 : 8'd2;
        end
      end
      dsat_pkg::ACT_P2L: begin
        if (!trivial && geo_sides_q == 8'd0) begin
          res.not_ready = 1'b1;
        end else begin
          base = trivial ? 64'd0 :
                 64'(geo_spt_q) * (64'(r.side) + 64'(geo_sides_q) * 64'(r.track));
          lg = (base + 64'(r.sector) - 64'd1) & lmask;
          res.logical = lg[23:0];
          res.out_of_range = (r.sector == 8'd0);
        end
      end
      dsat_pkg::ACT_L2P: begin
        lg = 64'(r.logical) & lmask;
        if (lg <= 64'd1) begin
          res.sector = lg[7:0] + 8'd1;
        end else if (geo_sides_q == 8'd0 || geo_spt_q == 8'd0) begin
          res.not_ready = 1'b1;
        end else begin
          cyl = 64'(geo_sides_q) * 64'(geo_spt_q);
          trk = lg / cyl;
          res.track  = trk[7:0];
          res.side   = 8'((lg / 64'(geo_spt_q)) % 64'(geo_sides_q));
          res.sector = 8'((lg % 64'(geo_spt_q)) + 64'd1);
          res.out_of_range = (trk > 64'd255);
        end
      end
      default: ;
    endcase
    res.geo_spt   = geo_spt_q;
    res.geo_sides = geo_sides_q;
    return res;
  endfunction

  // Random content for every field; callers override what matters
  function automatic xlat_req_t noise_req();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(xlat_req_t)-1:0];
  endfunction

  function automatic xlat_req_t mk_detect(input logic [7:0] first, input logic [15:0] spt,
                                          input logic [15:0] heads, input logic [7:0] media,
                                          input logic failed, input logic [23:0] total);
    xlat_req_t r;
    r = noise_req();
    r.action      = dsat_pkg::ACT_DETECT;
    r.boot_first  = first;
    r.boot_spt    = spt;
    r.boot_heads  = heads;
    r.media       = media;
    r.read_failed = failed;
    r.total       = total;
    return r;
  endfunction

  function automatic xlat_req_t mk_p2l(input logic [7:0] trk, input logic [7:0] sd,
                                       input logic [7:0] sec);
    xlat_req_t r;
    r = noise_req();
    r.action = dsat_pkg::ACT_P2L;
    r.track  = trk;
    r.side   = sd;
    r.sector = sec;
    return r;
  endfunction

  function automatic xlat_req_t mk_l2p(input logic [23:0] lg);
    xlat_req_t r;
    r = noise_req();
    r.action  = dsat_pkg::ACT_L2P;
    r.logical = lg;
    return r;
  endfunction

  function automatic xlat_res_t mk_res(input logic [23:0] lg, input logic [7:0] trk,
                                       input logic [7:0] sd, input logic [7:0] sec,
                                       input logic [7:0] gs, input logic [7:0] gh,
                                       input logic nr, input logic oor);
    xlat_res_t res;
    res.logical      = lg;
    res.track        = trk;
    res.side         = sd;
    res.sector       = sec;
    res.geo_spt      = gs;
    res.geo_sides    = gh;
    res.not_ready    = nr;
    res.out_of_range = oor;
    return res;
  endfunction

  function automatic void add_row(input xlat_req_t r, input bit typed, input xlat_res_t res);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.res   = res;
    stim_tab.push_back(row);
  endfunction

  // Random item: mostly plausible floppy addresses, some full-range noise
  function automatic xlat_req_t draw_request();
    xlat_req_t r;
    int        pick;
    r = noise_req();
    pick = $urandom_range(99);
    if (pick < 12) begin
      r.action = dsat_pkg::ACT_DETECT;
      r.read_failed = 1'b0;
      case ($urandom_range(5))
        0: r.read_failed = 1'b1;
        1, 2: begin
          r.boot_first = $urandom_range(1) ? dsat_pkg::JMP_NEAR : dsat_pkg::JMP_SHORT;
          if ($urandom_range(3) == 0) begin
            r.boot_spt   = 16'($urandom_range(255, 1));
            r.boot_heads = 16'($urandom_range(255, 1));
          end else begin
            r.boot_spt   = 16'($urandom_range(18, 8));
            r.boot_heads = 16'($urandom_range(2, 1));
          end
        end
        3: begin
          // jump present but a boot field out of range
          r.boot_first = $urandom_range(1) ? dsat_pkg::JMP_NEAR : dsat_pkg::JMP_SHORT;
          if ($urandom_range(1)) begin
            r.boot_spt = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 256));
          end else begin
            r.boot_heads = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 256));
          end
        end
        4: begin
          if (r.boot_first == dsat_pkg::JMP_NEAR || r.boot_first == dsat_pkg::JMP_SHORT) begin
            r.boot_first[0] = 1'b0;
          end
          r.media = 8'($urandom_range(255, 248));
        end
        default: begin
          if (r.boot_first == dsat_pkg::JMP_NEAR || r.boot_first == dsat_pkg::JMP_SHORT) begin
            r.boot_first[0] = 1'b0;
          end
          r.media = 8'($urandom_range(247, 0));
        end
      endcase
      if ($urandom_range(3) == 0) r.total = dsat_pkg::SS_360K_TOTAL;
    end else if (pick < 56) begin
      r.action = dsat_pkg::ACT_P2L;
      case ($urandom_range(7))
        0: begin
          r.track = 8'd0;
          r.side  = 8'd0;
        end
        1: ;
        default: begin
          r.track  = 8'($urandom_range(83));
          r.side   = 8'($urandom_range(geo_sides_q));
          r.sector = 8'($urandom_range(geo_spt_q));
        end
      endcase
    end else begin
      r.action = dsat_pkg::ACT_L2P;
      case ($urandom_range(7))
        0: r.logical = 24'($urandom_range(1));
        1: ;
        default: r.logical = 24'($urandom_range(int'(geo_spt_q) * int'(geo_sides_q) * 300));
      endcase
    end
    return r;
  endfunction

  task automatic put_payload(input xlat_req_t r);
    cmd.action             <= r.action;
    cmd.track_in           <= r.track;
    cmd.side_in            <= r.side;
    cmd.sector_in          <= r.sector;
    cmd.logical_in         <= r.logical;
    cmd.boot_first_byte    <= r.boot_first;
    cmd.boot_sectors_field <= r.boot_spt;
    cmd.boot_heads_field   <= r.boot_heads;
    cmd.fat_media_byte     <= r.media;
    cmd.read_failed        <= r.read_failed;
    cmd.total_sectors      <= r.total;
  endtask

  // Offer one item after a random idle gap; record its expected result on accept
  task automatic offer_item(input xlat_req_t r, input bit typed, input xlat_res_t typed_res);
    xlat_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    put_payload(r);
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    pred = translate_addr(r);
    pending_xlat.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending_xlat.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off when pressure starts
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (press_phase && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    xlat_res_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.logical_out, rsp.track_out, rsp.side_out, rsp.sector_out,
             rsp.geometry_sectors, rsp.geometry_sides, rsp.not_ready, rsp.out_of_range};
      if (pending_xlat.size() == 0) begin
        $display("%0t: result with nothing pending, got %h", $time, got);
        errors++;
      end else begin
        want = pending_xlat.pop_front();
        check_field("logical_out", want.logical, got.logical);
        check_field("track_out", want.track, got.track);
        check_field("side_out", want.side, got.side);
        check_field("sector_out", want.sector, got.sector);
        check_field("geometry_sectors", want.geo_spt, got.geo_spt);
        check_field("geometry_sides", want.geo_sides, got.geo_sides);
        check_field("not_ready", want.not_ready, got.not_ready);
        check_field("out_of_range", want.out_of_range, got.out_of_range);
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    cmd.valid <= 1'b0;
    put_payload('0);

    // Before detection: trivial addresses pass, the rest are not ready
    add_row(mk_l2p(24'd0), 1'b1, mk_res(24'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0, 1'b0));
    add_row(mk_l2p(24'd1), 1'b1, mk_res(24'd0, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 1'b0, 1'b0));
    add_row(mk_p2l(8'd0, 8'd0, 8'd1), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    add_row(mk_p2l(8'd0, 8'd0, 8'd0), 1'b1,
            mk_res(24'hFFFFFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
    add_row(mk_p2l(8'd1, 8'd0, 8'd1), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    add_row(mk_l2p(24'd2), 1'b1, mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    add_row(mk_l2p(24'hFFFFFF), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    // Read error wins, even over a valid boot sector
    add_row(mk_detect(8'h00, 16'd0, 16'd0, 8'h00, 1'b1, 24'd720), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd9, 8'd1, 1'b0, 1'b0));
    add_row(mk_detect(dsat_pkg::JMP_NEAR, 16'd18, 16'd2, 8'hFF, 1'b1, 24'd1440), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd9, 8'd2, 1'b0, 1'b0));
    add_row(mk_detect(dsat_pkg::JMP_SHORT, 16'd18, 16'd2, 8'h00, 1'b0, 24'd720), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd18, 8'd2, 1'b0, 1'b0));
    add_row(mk_l2p(24'hFFFFFF), 1'b0, '0);
    add_row(mk_p2l(8'hFF, 8'hFF, 8'h00), 1'b0, '0);
    add_row(mk_p2l(8'd0, 8'd0, 8'd0), 1'b1,
            mk_res(24'hFFFFFF, 8'd0, 8'd0, 8'd0, 8'd18, 8'd2, 1'b0, 1'b1));
    // Jump with a bad boot field falls back; the media byte is ignored
    add_row(mk_detect(dsat_pkg::JMP_SHORT, 16'd0, 16'd2, 8'hFF, 1'b0, 24'd720), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd9, 8'd1, 1'b0, 1'b0));
    add_row(mk_detect(dsat_pkg::JMP_NEAR, 16'd256, 16'd2, 8'h00, 1'b0, 24'd0), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd9, 8'd2, 1'b0, 1'b0));
    add_row(mk_detect(dsat_pkg::JMP_NEAR, 16'd2, 16'hFFFF, 8'h00, 1'b0, 24'd720), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd9, 8'd1, 1'b0, 1'b0));
    add_row(mk_detect(dsat_pkg::JMP_SHORT, 16'd255, 16'd255, 8'h00, 1'b0, 24'd0), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 1'b0));
    add_row(mk_l2p(24'hFFFFFF), 1'b0, '0);
    add_row(mk_p2l(8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    // Media descriptor: bit 1 picks 8 sectors, bit 0 picks 2 sides
    add_row(mk_detect(8'h00, 16'hFFFF, 16'hFFFF, 8'hF8, 1'b0, 24'd720), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd9, 8'd1, 1'b0, 1'b0));
    add_row(mk_detect(8'h00, 16'd0, 16'd0, 8'hFF, 1'b0, 24'd0), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd8, 8'd2, 1'b0, 1'b0));
    add_row(mk_detect(8'hE8, 16'd0, 16'd0, 8'hFA, 1'b0, 24'd0), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd8, 8'd1, 1'b0, 1'b0));
    add_row(mk_detect(dsat_pkg::JMP_NEAR, 16'd1, 16'd1, 8'h00, 1'b0, 24'hFFFFFF), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 1'b0, 1'b0));
    add_row(mk_l2p(24'd2), 1'b0, '0);
    add_row(mk_detect(8'h7F, 16'd0, 16'd0, 8'hF7, 1'b0, 24'hFFFFFF), 1'b1,
            mk_res(24'd0, 8'd0, 8'd0, 8'd0, 8'd9, 8'd2, 1'b0, 1'b0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table, then sender-light / receiver-heavy idling
    foreach (stim_tab[i]) offer_item(stim_tab[i].req, stim_tab[i].typed, stim_tab[i].res);
    for (int n = 0; n < PHASE_ITEMS; n++) offer_item(draw_request(), 1'b0, '0);
    drain_results();

    send_idle_pct = 72;
    rcv_idle_pct  = 36;
    for (int n = 0; n < PHASE_ITEMS; n++) offer_item(draw_request(), 1'b0, '0);
    drain_results();

    // No idling; the receiver opens with a long hold-off to back up the block
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    press_phase   = 1'b1;
    for (int n = 0; n < PHASE_ITEMS - 1; n++) offer_item(draw_request(), 1'b0, '0);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
